// ===== rtl/hmt_pkg.sv =====
// Shared types and codes for the hotkey match table.
// Item structs, table entry layout and status/command codes.
package hmt_pkg;

  localparam int unsigned TableEntriesDefault = 64;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_KEY      = 1'b1;

  localparam logic [1:0] ST_MATCHED    = 2'd0;
  localparam logic [1:0] ST_PASS       = 2'd1;
  localparam logic [1:0] ST_REGISTERED = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic        command;
    logic [7:0]  modifier_bits;
    logic [7:0]  key_code;
    logic [1:0]  action_kind;
    logic [31:0] action_argument;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  matched_kind;
    logic [31:0] matched_argument;
  } rsp_item_t;

  typedef struct packed {
    logic [7:0]  modifiers;
    logic [7:0]  key;
    logic [1:0]  kind;
    logic [31:0] argument;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan_en;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_is_key;
    logic scan_done;
  } dp_status_t;

endpackage

// ===== rtl/hmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hmt_ctrl.sv =====
// Controller FSM for the hotkey match table: accept, scan, deliver.
// Depends on hmt_pkg.
module hmt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  hmt_pkg::dp_status_t stat,
  output hmt_pkg::ctrl_cmd_t  cmd
);
  import hmt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  assign req_ready    = (state == S_IDLE);
  assign cmd.accept   = (state == S_IDLE) && req_valid;
  assign cmd.scan_en  = (state == S_SCAN);
  assign cmd.load_out = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.accept) begin
            state <= stat.item_is_key ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !req_ready)
    else $error("new item taken while one is in flight");

  a_load_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid && req_ready)
    else $error("result load did not raise rsp_valid or return to idle");

endmodule

// ===== rtl/hmt_dp.sv =====
// Datapath for the hotkey match table: entry RAM, fill count, scan and result.
// Depends on hmt_pkg and hmt_ram.
module hmt_dp #(
  parameter int unsigned TABLE_ENTRIES = hmt_pkg::TableEntriesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  hmt_pkg::req_item_t  req,
  output hmt_pkg::rsp_item_t  rsp,
  input  hmt_pkg::ctrl_cmd_t  cmd,
  output hmt_pkg::dp_status_t stat
);
  import hmt_pkg::*;

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW    = $bits(entry_t);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             rd_pend;
  logic             found;
  logic [7:0]       key_mods;
  logic [7:0]       key_q;
  logic [1:0]       res_status;
  logic [1:0]       res_kind;
  logic [31:0]      res_arg;

  logic             full;
  logic             we;
  logic             issue;
  logic             hit;
  entry_t           wentry;
  entry_t           rentry;
  logic [EW-1:0]    rdata;

  assign full  = (count == CNT_W'(TABLE_ENTRIES));
  assign we    = cmd.accept && (req.command == CMD_REGISTER) && !full;
  assign issue = cmd.scan_en && !found && (idx < count);

  assign wentry.modifiers = req.modifier_bits;
  assign wentry.key       = req.key_code;
  assign wentry.kind      = req.action_kind;
  assign wentry.argument  = req.action_argument;
  assign rentry           = entry_t'(rdata);

  assign hit = rd_pend && !found &&
               (rentry.modifiers == key_mods) && (rentry.key == key_q);

  assign stat.item_is_key = (req.command == CMD_KEY);
  assign stat.scan_done   = found || (!rd_pend && !(idx < count));

  hmt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (wentry),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (we) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.accept) begin
        idx   <= '0;
        found <= 1'b0;
      end else begin
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end
        if (hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_mods <= req.modifier_bits;
      key_q    <= req.key_code;
      res_kind <= '0;
      res_arg  <= '0;
      if (req.command == CMD_KEY) begin
        res_status <= ST_PASS;
      end else begin
        res_status <= full ? ST_FULL : ST_REGISTERED;
      end
    end else if (hit) begin
      res_status <= ST_MATCHED;
      res_kind   <= rentry.kind;
      res_arg    <= rentry.argument;
    end
    if (cmd.load_out) begin
      rsp.status           <= res_status;
      rsp.matched_kind     <= res_kind;
      rsp.matched_argument <= res_arg;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count past table size");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    we |-> !cmd.scan_en)
    else $error("table written during a scan");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    found |-> res_status == ST_MATCHED)
    else $error("match flagged without matched status");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> idx < count)
    else $error("scan read past filled entries");

endmodule

// ===== rtl/hotkey_match_table.sv =====
// Hotkey match table top level: first-match lookup over appended bindings.
// Depends on hmt_pkg, hmt_ctrl, hmt_dp (and hmt_ram through hmt_dp).
//
//   channel  handshake            payload
//   req      req_valid/req_ready  req  (hmt_pkg::req_item_t)
//   rsp      rsp_valid/rsp_ready  rsp  (hmt_pkg::rsp_item_t)
//
// One item at a time. A register item goes from accept straight to the finish state.
// For a keystroke item the scan reads the entry RAM one entry per cycle, drains
// the last read, and stops early at the first match.
// Reset clears the fill count but not the entries; entries are never cleared.
// A waiting result sits in the output register while the next item is taken.
module hotkey_match_table #(
  parameter int unsigned TABLE_ENTRIES = hmt_pkg::TableEntriesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  hmt_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output hmt_pkg::rsp_item_t rsp
);
  import hmt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  hmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hmt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// ===== tb/hmt_lookup_checker.sv =====
// Checker for the hotkey match table: watches both channels, predicts each result.
// Keeps its own binding table and compares results in order. Depends on hmt_pkg.
module hmt_lookup_checker #(
  parameter int unsigned TABLE_ENTRIES = hmt_pkg::TableEntriesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  hmt_pkg::req_item_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  hmt_pkg::rsp_item_t rsp,
  output int                 fail_count,
  output int                 pending
);
  import hmt_pkg::*;

  entry_t      bindings [TABLE_ENTRIES];
  int unsigned fill_level = 0;
  rsp_item_t   expected_rsp_q [$];
  int          fails = 0;

  function automatic rsp_item_t lookup_outcome(input req_item_t it);
    rsp_item_t r;
    r = '0;
    r.status = ST_PASS;
    if (it.command == CMD_REGISTER) begin
      if (fill_level >= TABLE_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        bindings[fill_level].modifiers = it.modifier_bits;
        bindings[fill_level].key       = it.key_code;
        bindings[fill_level].kind      = it.action_kind;
        bindings[fill_level].argument  = it.action_argument;
        fill_level++;
        r.status = ST_REGISTERED;
      end
    end else begin
      // earliest binding wins
      for (int i = 0; i < fill_level; i++) begin
        if (bindings[i].modifiers == it.modifier_bits && bindings[i].key == it.key_code) begin
          r.status           = ST_MATCHED;
          r.matched_kind     = bindings[i].kind;
          r.matched_argument = bindings[i].argument;
          return r;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rsp_item_t want;
    if (rst) begin
      fill_level = 0;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: status %0d kind %0d arg %h",
                     rsp.status, rsp.matched_kind, rsp.matched_argument);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status || rsp.matched_kind !== want.matched_kind ||
              rsp.matched_argument !== want.matched_argument) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp status %0d kind %0d arg %h, got status %0d kind %0d arg %h",
                       want.status, want.matched_kind, want.matched_argument,
                       rsp.status, rsp.matched_kind, rsp.matched_argument);
          end
        end
      end
      if (req_valid && req_ready)
        expected_rsp_q.push_back(lookup_outcome(req));
    end
    pending    <= expected_rsp_q.size();
    fail_count <= fails;
  end

endmodule

// ===== tb/hotkey_match_table_tb.sv =====
// Top of the hotkey match table testbench: clock, reset, stimulus and verdict.
// Depends on hmt_pkg, hotkey_match_table and hmt_lookup_checker.
module hotkey_match_table_tb;
  import hmt_pkg::*;

  localparam int unsigned TableDepth  = TableEntriesDefault;
  localparam int          RandomItems = 1150;
  localparam int          CycleLimit  = 500000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_item_t   req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_item_t   rsp;
  int          fail_count;
  int          pending;
  logic        quiet     = 1'b0;
  int unsigned cycles    = 0;
  logic [7:0]  bound_mods [$];
  logic [7:0]  bound_keys [$];

  hotkey_match_table #(.TABLE_ENTRIES(TableDepth)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  hmt_lookup_checker #(.TABLE_ENTRIES(TableDepth)) chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= quiet || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("hotkey_match_table_tb NOT OK");
      $finish;
    end
  end

  function automatic req_item_t bind_item(input logic [7:0] m, input logic [7:0] k,
                                          input logic [1:0] kind, input logic [31:0] arg);
    req_item_t it;
    it.command         = CMD_REGISTER;
    it.modifier_bits   = m;
    it.key_code        = k;
    it.action_kind     = kind;
    it.action_argument = arg;
    return it;
  endfunction

  // action fields are don't-care on a keystroke, so fill them with noise
  function automatic req_item_t key_item(input logic [7:0] m, input logic [7:0] k);
    req_item_t it;
    it.command         = CMD_KEY;
    it.modifier_bits   = m;
    it.key_code        = k;
    it.action_kind     = 2'($urandom);
    it.action_argument = $urandom;
    return it;
  endfunction

  task automatic send_item(input req_item_t it);
    if (!quiet && $urandom_range(99) < 18) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (it.command == CMD_REGISTER && bound_mods.size() < TableDepth) begin
      bound_mods.push_back(it.modifier_bits);
      bound_keys.push_back(it.key_code);
    end
  endtask

  task automatic drain_wait();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    req_item_t  it;
    int         pick;
    int         idx;
    int         flip;
    logic [7:0] m;
    logic [7:0] k;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table: keystrokes pass through, then bindings are added and looked up
    send_item(key_item(8'h00, 8'h00));
    send_item(key_item(8'hff, 8'hff));
    send_item(bind_item(8'h00, 8'h00, 2'd0, 32'h0000_0000));
    send_item(bind_item(8'hff, 8'hff, 2'd3, 32'hffff_ffff));
    send_item(bind_item(8'hff, 8'h00, 2'd1, 32'h0000_0001));
    send_item(bind_item(8'h00, 8'hff, 2'd2, 32'h8000_0000));
    send_item(bind_item(8'hff, 8'hff, 2'd0, 32'h1234_5678));
    send_item(bind_item(8'h55, 8'haa, 2'd1, 32'ha5a5_a5a5));
    send_item(bind_item(8'haa, 8'h55, 2'd2, 32'h5a5a_5a5a));
    send_item(key_item(8'h00, 8'h00));
    send_item(key_item(8'hff, 8'hff));
    send_item(key_item(8'hff, 8'h00));
    send_item(key_item(8'h00, 8'hff));
    send_item(key_item(8'h55, 8'haa));
    send_item(key_item(8'haa, 8'h55));
    send_item(key_item(8'h55, 8'h55));
    send_item(key_item(8'hff, 8'hfe));
    send_item(key_item(8'h7f, 8'hff));
    it = key_item(8'h55, 8'haa);
    it.action_kind     = 2'd3;
    it.action_argument = 32'hffff_ffff;
    send_item(it);
    drain_wait();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 300 || n == 800) drain_wait();
      if (n == 500) quiet <= 1'b1;
      if (n == 650) quiet <= 1'b0;
      pick = $urandom_range(99);
      idx  = (bound_mods.size() > 0) ? $urandom_range(bound_mods.size() - 1) : 0;
      if (pick < 25) begin
        if (bound_mods.size() > 0 && $urandom_range(9) == 0)
          it = bind_item(bound_mods[idx], bound_keys[idx], 2'($urandom), $urandom);
        else
          it = bind_item(8'($urandom), 8'($urandom), 2'($urandom), $urandom);
      end else if (pick < 70 && bound_mods.size() > 0) begin
        it = key_item(bound_mods[idx], bound_keys[idx]);
      end else if (pick < 85 && bound_mods.size() > 0) begin
        // near miss: one bit off a stored binding
        m    = bound_mods[idx];
        k    = bound_keys[idx];
        flip = $urandom_range(15);
        if (flip < 8) m[flip] = ~m[flip];
        else k[flip - 8] = ~k[flip - 8];
        it = key_item(m, k);
      end else begin
        it = key_item(8'($urandom), 8'($urandom));
      end
      send_item(it);
    end

    drain_wait();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("hotkey_match_table_tb OK");
    end else begin
      $display("hotkey_match_table_tb NOT OK");
    end
    $finish;
  end

endmodule
